// ===== src/dnlbpc_pkg.sv =====
`default_nettype none
package dnlbpc_pkg;
  localparam int unsigned MaxRadius = 63;
  localparam int unsigned NormDepth = 4096;
  localparam int unsigned RadiusW = 6;
  localparam int unsigned CountW = 40;
  localparam int unsigned LineW = 2;
  localparam int unsigned PlaneW = 8;
  localparam int unsigned PrefixW = 16;
  localparam logic [0:0] RegLatticeMode = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StPlane,
    StPrefix,
    StSum,
    StDrain,
    StOut
  } state_e;
endpackage
`default_nettype wire

// ===== src/dnlbpc_if.sv =====
`default_nettype none
interface dnlbpc_in_if;
  logic                               valid;
  logic                               ready;
  logic [dnlbpc_pkg::RadiusW-1:0]     radius;
  modport source (output valid, output radius, input ready);
  modport sink (input valid, input radius, output ready);
endinterface

interface dnlbpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [dnlbpc_pkg::CountW-1:0]      point_count;
  modport source (output valid, output point_count, input ready);
  modport sink (input valid, input point_count, output ready);
endinterface
`default_nettype wire

// ===== src/dn_lattice_ball_point_counter.sv =====
// channel   dir  payload              handshake
// in_w      in   radius[5:0]          valid/ready
// out_w     out  point_count[39:0]    valid/ready
// cfg       in   lattice_mode @ 0x0   apb, pready always high
//
// one word at a time; clear the profiles, then build the plane histogram
// (one memory read-modify-write per cycle, line profile built from the
// central column in the same pass, one spare step lets the last update
// land), then the prefix pass and the product pass; the word is taken
// before the clear and the result is handed out after the product pass.
// the plane memory port sets the rate. reset: idle, mode D4.
// the result waits in the output register; the next word is taken only
// after it has left.
`default_nettype none
module dn_lattice_ball_point_counter #(
  parameter int unsigned MAX_RADIUS = dnlbpc_pkg::MaxRadius,
  parameter int unsigned NORM_DEPTH = dnlbpc_pkg::NormDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dnlbpc_in_if.sink  in_w,
  dnlbpc_out_if.source out_w,
  input  wire logic  psel,
  input  wire logic  penable,
  input  wire logic  pwrite,
  input  wire logic  [1:0] paddr,
  input  wire logic  [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic       pready
);
  localparam int unsigned AW = (NORM_DEPTH > 1) ? $clog2(NORM_DEPTH) : 1;
  localparam int unsigned CW = $clog2(2*MAX_RADIUS+2);
  localparam int unsigned RW = dnlbpc_pkg::RadiusW;
  localparam int unsigned NW = 2*CW + 1;
  localparam int unsigned LW = dnlbpc_pkg::LineW;
  localparam int unsigned PW = dnlbpc_pkg::PlaneW;
  localparam int unsigned XW = dnlbpc_pkg::PrefixW;
  localparam int unsigned KW = dnlbpc_pkg::CountW;
  localparam logic [NW-1:0] LimMax = NW'(NORM_DEPTH-1);

  logic mode_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(dnlbpc_pkg::RegLatticeMode)) ? {31'b0, mode_q} : 32'b0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b1;
    else if (psel && penable && pwrite && paddr == 2'(dnlbpc_pkg::RegLatticeMode))
      mode_q <= pwdata[0];
  end

  // memories: one entry per norm, even and odd halves side by side
  logic [2*LW-1:0] line_mem [NORM_DEPTH];
  logic [2*PW-1:0] plane_mem [NORM_DEPTH];
  logic [2*XW-1:0] pre_mem [NORM_DEPTH];

  dnlbpc_pkg::state_e st_q, st_d;
  logic [CW-1:0] r_q, i_q, j_q, r_d, i_d, j_d;
  logic [AW-1:0] lim_q, lim_d, a_q, a_d;
  logic [KW-1:0] acc_q, acc_d;
  logic [2*XW-1:0] run_q, run_d;

  // read port results
  logic [2*LW-1:0] line_rd_q;
  logic [2*PW-1:0] plane_rd_q;
  logic [2*XW-1:0] pre_rd_q;

  // stage-1 (address phase) registers for rmw / sum
  logic          s1_v_q, s1_par_q, s1_line_q;
  logic [AW-1:0] s1_a_q;
  logic          s1_v_d, s1_par_d, s1_line_d;
  logic [AW-1:0] s1_rd_addr, s1_pre_addr;

  // distances and norm for the plane walk
  logic [CW-1:0] x, y;
  logic [NW-1:0] norm, lim_raw;
  logic [RW-1:0] rin;
  always_comb begin
    x = (i_q >= r_q) ? i_q - r_q : r_q - i_q;
    y = (j_q >= r_q) ? j_q - r_q : r_q - j_q;
    norm = NW'(x*x) + NW'(y*y);
    rin = in_w.radius;
    if (32'(rin) > MAX_RADIUS) rin = RW'(MAX_RADIUS);
    lim_raw = NW'(rin) * NW'(rin);
  end

  // forwarding: two plane updates to one norm in consecutive cycles
  logic [2*PW-1:0] plane_cur;
  logic [2*LW-1:0] line_cur;
  logic [2*PW-1:0] plane_wr_q;
  logic [2*LW-1:0] line_wr_q;
  logic [AW-1:0]   wr_a_q;
  logic            wr_v_q;
  always_comb begin
    plane_cur = (wr_v_q && wr_a_q == s1_a_q) ? plane_wr_q : plane_rd_q;
    line_cur = (wr_v_q && wr_a_q == s1_a_q) ? line_wr_q : line_rd_q;
  end

  logic [2*PW-1:0] plane_new;
  logic [2*LW-1:0] line_new;
  always_comb begin
    plane_new = plane_cur;
    line_new = line_cur;
    if (s1_par_q) plane_new[2*PW-1:PW] = plane_cur[2*PW-1:PW] + 1'b1;
    else plane_new[PW-1:0] = plane_cur[PW-1:0] + 1'b1;
    if (s1_line_q) begin
      if (s1_par_q) line_new[2*LW-1:LW] = line_cur[2*LW-1:LW] + 1'b1;
      else line_new[LW-1:0] = line_cur[LW-1:0] + 1'b1;
    end
  end

  // product pass operands
  logic [PW-1:0] fe, fo;
  logic [KW-1:0] prod;
  always_comb begin
    fe = mode_q ? plane_rd_q[PW-1:0] : PW'(line_rd_q[LW-1:0]);
    fo = mode_q ? plane_rd_q[2*PW-1:PW] : PW'(line_rd_q[2*LW-1:LW]);
    prod = KW'(fe * pre_rd_q[XW-1:0]) + KW'(fo * pre_rd_q[2*XW-1:XW]);
  end

  always_comb begin
    st_d = st_q; r_d = r_q; i_d = i_q; j_d = j_q; lim_d = lim_q; a_d = a_q;
    acc_d = acc_q; run_d = run_q;
    s1_v_d = 1'b0; s1_par_d = 1'b0; s1_line_d = 1'b0;
    s1_rd_addr = a_q; s1_pre_addr = lim_q - a_q;
    in_w.ready = 1'b0;
    out_w.valid = 1'b0;
    case (st_q)
      dnlbpc_pkg::StIdle: begin
        in_w.ready = 1'b1;
        if (in_w.valid) begin
          r_d = CW'(rin);
          lim_d = (lim_raw > LimMax) ? AW'(LimMax) : AW'(lim_raw);
          a_d = '0; st_d = dnlbpc_pkg::StClear;
        end
      end
      dnlbpc_pkg::StClear: begin
        a_d = a_q + 1'b1;
        if (a_q == lim_q) begin
          i_d = '0; j_d = '0; st_d = dnlbpc_pkg::StPlane;
        end
      end
      dnlbpc_pkg::StPlane: begin
        // spare step at row 2R+1: its norm is above the limit, and the
        // update of the last point is written meanwhile
        s1_rd_addr = AW'(norm);
        s1_v_d = (norm <= NW'(lim_q));
        s1_par_d = i_q[0] ^ j_q[0];
        s1_line_d = (j_q == r_q);
        if (i_q == CW'(2*r_q + 1)) begin
          a_d = '0; run_d = '0; st_d = dnlbpc_pkg::StPrefix;
        end else if (j_q == 2*r_q) begin
          j_d = '0; i_d = i_q + 1'b1;
        end else j_d = j_q + 1'b1;
      end
      dnlbpc_pkg::StPrefix: begin
        // plane data read last cycle at a_q-1 once s1_v_q
        if (s1_v_q) run_d = {run_q[2*XW-1:XW] + XW'(plane_rd_q[2*PW-1:PW]),
                             run_q[XW-1:0] + XW'(plane_rd_q[PW-1:0])};
        s1_v_d = 1'b1;
        if (s1_v_q && s1_a_q == lim_q) begin
          a_d = '0; acc_d = '0; s1_v_d = 1'b0; st_d = dnlbpc_pkg::StSum;
        end else if (!(s1_v_q && a_q > lim_q)) a_d = a_q + 1'b1;
      end
      dnlbpc_pkg::StSum: begin
        if (s1_v_q) acc_d = acc_q + prod;
        s1_v_d = 1'b1;
        a_d = a_q + 1'b1;
        if (a_q == lim_q) st_d = dnlbpc_pkg::StDrain;
      end
      dnlbpc_pkg::StDrain: begin
        acc_d = acc_q + prod;
        st_d = dnlbpc_pkg::StOut;
      end
      dnlbpc_pkg::StOut: begin
        out_w.valid = 1'b1;
        if (out_w.ready) st_d = dnlbpc_pkg::StIdle;
      end
      default: st_d = dnlbpc_pkg::StIdle;
    endcase
  end
  assign out_w.point_count = acc_q;

  // prefix write data for address s1_a_q
  logic [2*XW-1:0] pre_wr;
  assign pre_wr = {run_q[2*XW-1:XW] + XW'(plane_rd_q[2*PW-1:PW]),
                   run_q[XW-1:0] + XW'(plane_rd_q[PW-1:0])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dnlbpc_pkg::StIdle; acc_q <= '0; s1_v_q <= 1'b0; wr_v_q <= 1'b0;
    end else begin
      st_q <= st_d; acc_q <= acc_d; s1_v_q <= s1_v_d;
      wr_v_q <= (st_q == dnlbpc_pkg::StPlane) && s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; i_q <= i_d; j_q <= j_d; lim_q <= lim_d; a_q <= a_d; run_q <= run_d;
    s1_a_q <= s1_rd_addr; s1_par_q <= s1_par_d; s1_line_q <= s1_line_d;
    plane_wr_q <= plane_new; line_wr_q <= line_new; wr_a_q <= s1_a_q;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    plane_rd_q <= plane_mem[s1_rd_addr];
    line_rd_q <= line_mem[s1_rd_addr];
    pre_rd_q <= pre_mem[s1_pre_addr];
    if (st_q == dnlbpc_pkg::StClear) begin
      plane_mem[a_q] <= '0; line_mem[a_q] <= '0;
    end else if (st_q == dnlbpc_pkg::StPlane && s1_v_q) begin
      plane_mem[s1_a_q] <= plane_new; line_mem[s1_a_q] <= line_new;
    end
    if (st_q == dnlbpc_pkg::StPrefix && s1_v_q && s1_a_q <= lim_q)
      pre_mem[s1_a_q] <= pre_wr;
  end

`ifndef ASSERT_OFF
  a_out_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_w.valid |-> st_q == dnlbpc_pkg::StOut) else $error("valid outside done");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_w.ready |-> !out_w.valid) else $error("take while result pending");
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == dnlbpc_pkg::StOut) |=> (st_q == dnlbpc_pkg::StIdle) || $stable(acc_q))
    else $error("result changed");
`endif
endmodule
`default_nettype wire

// ===== verif/dn_lattice_ball_point_counter_tb.sv =====
`default_nettype none
module dn_lattice_ball_point_counter_tb;

  // lattice selection codes for the mode register
  localparam logic ModeD3 = 1'b0;
  localparam logic ModeD4 = 1'b1;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned HoldOffCycles = 60000;
  localparam int unsigned RandomWords = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // apb configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  dnlbpc_in_if  in_w ();
  dnlbpc_out_if out_w ();

  dn_lattice_ball_point_counter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_w    (in_w.sink),
    .out_w   (out_w.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected point counts, oldest first
  logic [dnlbpc_pkg::CountW-1:0] count_q[$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  logic              mode_now = ModeD4;  // reset value of the register
  logic              hold_off_req = 1'b0;

  // directed words: expected count typed only where it is obvious
  typedef struct {
    logic [dnlbpc_pkg::RadiusW-1:0] radius;
    logic                           mode;
    bit                             known;
    logic [dnlbpc_pkg::CountW-1:0]  count;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // first rows run in the reset mode (D4)
    '{6'd0,  ModeD4, 1'b1, 40'd1},   // origin only
    '{6'd1,  ModeD4, 1'b1, 40'd1},   // unit vectors have odd sum
    '{6'd2,  ModeD4, 1'b1, 40'd49},  // origin, 24 roots, 24 of norm 4
    '{6'd63, ModeD4, 1'b0, 40'd0},   // largest radius
    '{6'd32, ModeD4, 1'b0, 40'd0},
    '{6'd31, ModeD4, 1'b0, 40'd0},
    '{6'd3,  ModeD4, 1'b0, 40'd0},
    '{6'd0,  ModeD3, 1'b1, 40'd1},
    '{6'd1,  ModeD3, 1'b1, 40'd1},
    '{6'd2,  ModeD3, 1'b1, 40'd19},  // origin, 12 roots, 6 of norm 4
    '{6'd63, ModeD3, 1'b0, 40'd0},
    '{6'd42, ModeD3, 1'b0, 40'd0},
    '{6'd21, ModeD3, 1'b0, 40'd0},
    '{6'd5,  ModeD4, 1'b0, 40'd0}
  };

  // counts lattice points by parity-split norm profiles of lines and planes
  function automatic logic [dnlbpc_pkg::CountW-1:0] count_ball_points(
      logic [dnlbpc_pkg::RadiusW-1:0] radius, logic mode);
    logic [dnlbpc_pkg::LineW-1:0]   line_even[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::LineW-1:0]   line_odd[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::PlaneW-1:0]  plane_even[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::PlaneW-1:0]  plane_odd[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::PrefixW-1:0] pre_even[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::PrefixW-1:0] pre_odd[dnlbpc_pkg::NormDepth];
    logic [dnlbpc_pkg::PrefixW-1:0] run_even, run_odd;
    logic [dnlbpc_pkg::CountW-1:0]  total;
    int unsigned r, lim, x, y, m;
    r = radius;
    if (r > dnlbpc_pkg::MaxRadius) r = dnlbpc_pkg::MaxRadius;
    lim = r * r;
    if (lim > dnlbpc_pkg::NormDepth - 1) lim = dnlbpc_pkg::NormDepth - 1;
    for (int k = 0; k < dnlbpc_pkg::NormDepth; k++) begin
      line_even[k] = '0; line_odd[k] = '0;
      plane_even[k] = '0; plane_odd[k] = '0;
    end
    for (int unsigned i = 0; i <= 2 * r; i++) begin
      x = (i >= r) ? i - r : r - i;
      m = x * x;
      if (m <= lim) begin
        if ((i & 1) == (r & 1)) line_even[m]++;
        else line_odd[m]++;
      end
      for (int unsigned j = 0; j <= 2 * r; j++) begin
        y = (j >= r) ? j - r : r - j;
        m = x * x + y * y;
        if (m <= lim) begin
          if (((i + j) & 1) == 0) plane_even[m]++;
          else plane_odd[m]++;
        end
      end
    end
    run_even = '0;
    run_odd = '0;
    for (int unsigned k = 0; k <= lim; k++) begin
      run_even += plane_even[k];
      run_odd += plane_odd[k];
      pre_even[k] = run_even;
      pre_odd[k] = run_odd;
    end
    // same-parity products, d3 pairs line with plane prefix, d4 plane with prefix
    total = '0;
    for (int unsigned k = 0; k <= lim; k++) begin
      if (mode == ModeD3) begin
        total += dnlbpc_pkg::CountW'(line_even[k]) * dnlbpc_pkg::CountW'(pre_even[lim - k]);
        total += dnlbpc_pkg::CountW'(line_odd[k]) * dnlbpc_pkg::CountW'(pre_odd[lim - k]);
      end else begin
        total += dnlbpc_pkg::CountW'(plane_even[k]) * dnlbpc_pkg::CountW'(pre_even[lim - k]);
        total += dnlbpc_pkg::CountW'(plane_odd[k]) * dnlbpc_pkg::CountW'(pre_odd[lim - k]);
      end
    end
    return total;
  endfunction

  // apb write: setup then access, register taken at the access edge
  task automatic write_mode(logic mode);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(4 * dnlbpc_pkg::RegLatticeMode);
    pwdata <= {31'd0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_now = mode;
  endtask

  // wait until every expected count is back
  task automatic drain_counts();
    while (count_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // offer one word and hold it until taken, then record its expected count
  task automatic send_word(logic [dnlbpc_pkg::RadiusW-1:0] radius, bit known,
                           logic [dnlbpc_pkg::CountW-1:0] count);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 2000) : $urandom_range(1, 30);
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    in_w.radius <= radius;
    @(posedge clk_i);
    while (!(in_w.valid && in_w.ready)) @(posedge clk_i);
    count_q.push_back(known ? count : count_ball_points(radius, mode_now));
  endtask

  // receiver: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int unsigned len;
    out_w.ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_w.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      len = $urandom_range(1, 60);
      out_w.ready <= ($urandom_range(0, 2) != 0);
      repeat (len) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_w.valid && out_w.ready) begin
      if (count_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: count %0d", out_w.point_count);
        mismatches++;
      end else begin
        if (out_w.point_count !== count_q[0]) begin
          if (mismatches < 10)
            $display("count mismatch: expected %0d, actual %0d",
                     count_q[0], out_w.point_count);
          mismatches++;
        end
        void'(count_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [dnlbpc_pkg::RadiusW-1:0] r;
    logic               phase_modes[4];
    phase_modes = '{ModeD4, ModeD3, ModeD4, ModeD3};
    in_w.valid <= 1'b0;
    in_w.radius <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, first rows check the reset mode
    foreach (dir_rows[k]) begin
      if (dir_rows[k].mode != mode_now) begin
        in_w.valid <= 1'b0;
        drain_counts();
        write_mode(dir_rows[k].mode);
      end
      send_word(dir_rows[k].radius, dir_rows[k].known, dir_rows[k].count);
    end

    // random part in phases across both modes, mostly small radii
    for (int p = 0; p < 4; p++) begin
      in_w.valid <= 1'b0;
      drain_counts();
      write_mode(phase_modes[p]);
      if (p == 1) hold_off_req = 1'b1;  // output blocked, input backs up
      for (int n = 0; n < RandomWords / 4; n++) begin
        r = ($urandom_range(0, 4) == 0) ? dnlbpc_pkg::RadiusW'($urandom_range(0, 63))
                                        : dnlbpc_pkg::RadiusW'($urandom_range(0, 15));
        send_word(r, 1'b0, '0);
      end
    end
    in_w.valid <= 1'b0;

    drain_counts();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
